/* hdl/dspl_pkg.sv */
// Package for the depth-sorted polygon list: sizes, opcodes, shared types.
// No dependencies.
`default_nettype none
package dspl_pkg;
    localparam int MaxEntriesDef  = 128;
    localparam int MaxVerticesDef = 16;
    localparam int MaxOut         = 16;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_STAGE  = 2'd1,
        OP_COMMIT = 2'd2,
        OP_EMIT   = 2'd3
    } opcode_t;
endpackage
`default_nettype wire

/* hdl/dspl_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module dspl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hdl/depth_sorted_polygon_list.sv */
// Depth-sorted polygon list. Stage and clear finish on acceptance. Commit copies the
// MAX_VERTICES staged words (one a cycle), compares with the head, then walks the chain
// with a read and a compare state per entry, plus a link write for a mid-chain split.
// Emit: ST_EMITRD, then one word a cycle while m_ready is high; done word set on acceptance.
// One item at a time. Synchronous active-low reset empties the list; table RAMs are
// not cleared (only entries below the fill count are read). Uses dspl_pkg, dspl_ram.
`default_nettype none
module depth_sorted_polygon_list
    import dspl_pkg::*;
#(
    parameter int MAX_ENTRIES  = MaxEntriesDef,
    parameter int MAX_VERTICES = MaxVerticesDef
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_opcode,
    input  wire logic [3:0]         s_vertex_slot,
    input  wire logic signed [15:0] s_vertex_x,
    input  wire logic signed [15:0] s_vertex_y,
    input  wire logic [4:0]         s_point_count,
    input  wire logic [7:0]         s_colour,
    input  wire logic signed [31:0] s_depth,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_done_res,
    output logic [7:0]              m_out_colour,
    output logic [4:0]              m_out_count,
    output logic [3:0]              m_out_slot,
    output logic signed [15:0]      m_out_x,
    output logic signed [15:0]      m_out_y,
    output logic                    m_last_point
);
    localparam int EW = $clog2(MAX_ENTRIES);
    localparam int LW = $clog2(MAX_ENTRIES + 1);
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int AW = EW + VW;
    localparam int NOUT = (MAX_VERTICES < MaxOut) ? MAX_VERTICES : MaxOut;
    localparam logic [LW-1:0] END_LINK = LW'(MAX_ENTRIES);

    typedef enum logic [3:0] {
        ST_IDLE, ST_COPY, ST_HEADRD, ST_HEADCMP, ST_WALKRD, ST_WALKCMP,
        ST_EMITRD, ST_EMITOUT, ST_DONE
    } state_t;

    state_t            state_reg;
    logic [LW-1:0]     head_reg, total_reg, cursor_reg;
    logic [31:0]       staged_reg [MAX_VERTICES];
    logic [EW-1:0]     new_reg, cur_reg;
    logic [31:0]       depth_reg;
    logic [VW:0]       idx_reg;

    // RAM ports
    logic              dep_we, cc_we, vtx_we, lnk_we;
    logic [EW-1:0]     dep_wa, dep_ra, cc_ra, lnk_wa, lnk_ra;
    logic [31:0]       dep_rd;
    logic [12:0]       cc_rd;
    logic [LW-1:0]     lnk_wd, lnk_rd;
    logic [AW-1:0]     vtx_wa, vtx_ra;
    logic [31:0]       vtx_rd;
    logic [4:0]        cnt_sat;

    // Second link write (new -> next) for a split is issued after the walk, while s_ready is held low.
    logic [LW-1:0] nx_reg;
    logic          fix_reg;

    assign cnt_sat = (s_point_count > 5'(MAX_VERTICES)) ? 5'(MAX_VERTICES) : s_point_count;

    dspl_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_dep (
        .aclk, .we(dep_we), .waddr(dep_wa), .wdata(s_depth), .raddr(dep_ra), .rdata(dep_rd));
    dspl_ram #(.WIDTH(13), .DEPTH(MAX_ENTRIES)) u_cc (
        .aclk, .we(cc_we), .waddr(dep_wa), .wdata({cnt_sat, s_colour}),
        .raddr(cc_ra), .rdata(cc_rd));
    dspl_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES * MAX_VERTICES)) u_vtx (
        .aclk, .we(vtx_we), .waddr(vtx_wa), .wdata(staged_reg[idx_reg[VW-1:0]]),
        .raddr(vtx_ra), .rdata(vtx_rd));
    dspl_ram #(.WIDTH(LW), .DEPTH(MAX_ENTRIES)) u_lnk (
        .aclk, .we(lnk_we), .waddr(lnk_wa), .wdata(lnk_wd), .raddr(lnk_ra), .rdata(lnk_rd));

    logic deeper;
    assign deeper = $signed(depth_reg) > $signed(dep_rd);

    assign s_ready = (state_reg == ST_IDLE) && !fix_reg;

    always_comb begin
        dep_we = 1'b0;
        cc_we  = 1'b0;
        dep_wa = total_reg[EW-1:0];
        vtx_we = (state_reg == ST_COPY);
        vtx_wa = {new_reg, idx_reg[VW-1:0]};
        lnk_we = 1'b0;
        lnk_wa = new_reg;
        lnk_wd = END_LINK;
        dep_ra = cur_reg;
        lnk_ra = cur_reg;
        cc_ra  = cursor_reg[EW-1:0];
        vtx_ra = {cursor_reg[EW-1:0], idx_reg[VW-1:0]};
        if (state_reg == ST_IDLE && s_valid && s_ready && s_opcode == OP_COMMIT
                && total_reg < LW'(MAX_ENTRIES)) begin
            dep_we = 1'b1;
            cc_we  = 1'b1;
        end
        if (fix_reg) begin
            lnk_we = 1'b1;
            lnk_wa = new_reg;
            lnk_wd = nx_reg;
        end
        case (state_reg)
            ST_HEADRD: dep_ra = head_reg[EW-1:0];
            ST_HEADCMP: begin
                lnk_we = 1'b1;
                lnk_wd = (new_reg != '0 && deeper) ? head_reg : END_LINK;
                lnk_ra = head_reg[EW-1:0];
            end
            ST_WALKRD: begin
                dep_ra = lnk_rd[EW-1:0];
            end
            ST_WALKCMP: begin
                lnk_ra = lnk_rd[EW-1:0];
                if (lnk_rd == END_LINK) begin
                    lnk_we = 1'b1;
                    lnk_wa = cur_reg;
                    lnk_wd = LW'(new_reg);
                end else if (deeper) begin
                    lnk_we = 1'b1;
                    lnk_wa = cur_reg;
                    lnk_wd = LW'(new_reg);
                end
            end
            ST_EMITRD: lnk_ra = cursor_reg[EW-1:0];
            ST_EMITOUT: begin
                lnk_ra = cursor_reg[EW-1:0];
                vtx_ra = {cursor_reg[EW-1:0],
                          (!m_valid || m_ready) ? VW'(idx_reg + 1'b1) : idx_reg[VW-1:0]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            total_reg  <= '0;
            cursor_reg <= END_LINK;
            m_valid    <= 1'b0;
            fix_reg    <= 1'b0;
            for (int i = 0; i < MAX_VERTICES; i++) staged_reg[i] <= '0;
        end else begin
            fix_reg <= (state_reg == ST_WALKCMP) && (lnk_rd != END_LINK) && deeper;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        case (opcode_t'(s_opcode))
                            OP_CLEAR: begin
                                head_reg   <= '0;
                                total_reg  <= '0;
                                cursor_reg <= END_LINK;
                            end
                            OP_STAGE: begin
                                if ({1'b0, s_vertex_slot} < 5'(MAX_VERTICES))
                                    staged_reg[s_vertex_slot[VW-1:0]] <=
                                        {s_vertex_y, s_vertex_x};
                            end
                            OP_COMMIT: begin
                                if (total_reg < LW'(MAX_ENTRIES)) begin
                                    new_reg   <= total_reg[EW-1:0];
                                    depth_reg <= s_depth;
                                    total_reg <= total_reg + 1'b1;
                                    idx_reg   <= '0;
                                    state_reg <= ST_COPY;
                                end
                            end
                            default: begin
                                idx_reg <= '0;
                                if (cursor_reg >= total_reg) begin
                                    cursor_reg   <= END_LINK;
                                    state_reg    <= ST_DONE;
                                    m_valid      <= 1'b1;
                                    m_done_res   <= 1'b1;
                                    m_out_colour <= '0;
                                    m_out_count  <= '0;
                                    m_out_slot   <= '0;
                                    m_out_x      <= '0;
                                    m_out_y      <= '0;
                                    m_last_point <= 1'b1;
                                end else begin
                                    state_reg <= ST_EMITRD;
                                end
                            end
                        endcase
                    end
                end
                ST_COPY: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == (VW+1)'(MAX_VERTICES - 1)) begin
                        if (new_reg == '0) begin
                            state_reg <= ST_HEADCMP;
                        end else begin
                            state_reg <= ST_HEADRD;
                        end
                    end
                end
                ST_HEADRD: state_reg <= ST_HEADCMP;
                ST_HEADCMP: begin
                    if (new_reg == '0 || deeper) begin
                        head_reg   <= LW'(new_reg);
                        cursor_reg <= LW'(new_reg);
                        state_reg  <= ST_IDLE;
                    end else begin
                        cur_reg   <= head_reg[EW-1:0];
                        state_reg <= ST_WALKRD;
                    end
                end
                ST_WALKRD: state_reg <= ST_WALKCMP;
                ST_WALKCMP: begin
                    if (lnk_rd == END_LINK) begin
                        cursor_reg <= head_reg;
                        state_reg  <= ST_IDLE;
                    end else if (deeper) begin
                        nx_reg     <= lnk_rd;
                        cursor_reg <= head_reg;
                        state_reg  <= ST_IDLE;
                    end else begin
                        cur_reg   <= lnk_rd[EW-1:0];
                        state_reg <= ST_WALKRD;
                    end
                end
                ST_EMITRD: begin
                    state_reg <= ST_EMITOUT;
                    m_valid   <= 1'b0;
                    idx_reg   <= '0;
                end
                ST_EMITOUT: begin
                    if (!m_valid || m_ready) begin
                        if (m_valid && m_last_point) begin
                            m_valid    <= 1'b0;
                            cursor_reg <= lnk_rd;
                            state_reg  <= ST_IDLE;
                        end else begin
                            m_valid      <= 1'b1;
                            m_done_res   <= 1'b0;
                            m_out_colour <= cc_rd[7:0];
                            m_out_count  <= cc_rd[12:8];
                            m_out_slot   <= 4'(idx_reg);
                            m_out_x      <= vtx_rd[15:0];
                            m_out_y      <= vtx_rd[31:16];
                            m_last_point <= ((idx_reg + 1'b1) >= (VW+1)'(cc_rd[12:8]))
                                            || (idx_reg == (VW+1)'(NOUT - 1));
                            idx_reg      <= idx_reg + 1'b1;
                        end
                    end
                end
                ST_DONE: begin
                    if (m_ready) begin
                        m_valid   <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_idle_no_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid);
    a_output_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable({m_done_res, m_out_colour,
            m_out_count, m_out_slot, m_out_x, m_out_y, m_last_point}));
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= LW'(MAX_ENTRIES));
    a_done_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_last_point && m_out_count == '0);
endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking bench for depth_sorted_polygon_list: drives opcode words through
// the valid/ready input and checks every output word against a built-in predictor.
// Depends on dspl_pkg and the block's RTL.
`default_nettype none
module tb
    import dspl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NENT  = MaxEntriesDef;
    localparam int NVERT = MaxVerticesDef;
    localparam int ENDC  = NENT;

    typedef struct packed {
        logic        done_res;
        logic [7:0]  colour;
        logic [4:0]  count;
        logic [3:0]  slot;
        logic [15:0] x;
        logic [15:0] y;
        logic        last;
    } point_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_opcode = '0;
    logic [3:0] s_vertex_slot = '0;
    logic signed [15:0] s_vertex_x = '0;
    logic signed [15:0] s_vertex_y = '0;
    logic [4:0] s_point_count = '0;
    logic [7:0] s_colour = '0;
    logic signed [31:0] s_depth = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_done_res;
    logic [7:0] m_out_colour;
    logic [4:0] m_out_count;
    logic [3:0] m_out_slot;
    logic signed [15:0] m_out_x;
    logic signed [15:0] m_out_y;
    logic m_last_point;

    depth_sorted_polygon_list u_dut (.*);

    always #6 aclk = ~aclk;

    // predictor state
    logic signed [31:0] tab_depth [NENT];
    logic [4:0]  tab_count [NENT];
    logic [7:0]  tab_colour [NENT];
    logic [31:0] tab_vert [NENT][NVERT];
    int          tab_link [NENT];
    int          head_idx, fill, cursor;
    logic [31:0] staged [NVERT];

    point_word_t expected_points[$];
    int  errors = 0;
    int  cycle = 0;
    int  send_idle = 0;
    int  recv_stall = 0;
    bit  hold_off = 0;
    localparam int LIMIT = 3000000;

    task automatic link_polygon(input int e, input logic signed [31:0] d);
        int cur;
        int nx;
        bit placed;
        tab_link[e] = ENDC;
        if (e == 0) begin
            head_idx = 0;
            return;
        end
        if (d > tab_depth[head_idx]) begin
            tab_link[e] = head_idx;
            head_idx = e;
            return;
        end
        cur = head_idx;
        placed = 0;
        while (!placed && tab_link[cur] < ENDC) begin
            nx = tab_link[cur];
            if (d > tab_depth[nx]) begin
                tab_link[cur] = e;
                tab_link[e] = nx;
                placed = 1;
            end else
                cur = nx;
        end
        if (!placed) tab_link[cur] = e;
    endtask

    task automatic predict(input logic [1:0] op, input logic [3:0] sl,
                           input logic [15:0] x, input logic [15:0] y,
                           input logic [4:0] pc, input logic [7:0] col,
                           input logic signed [31:0] d);
        int e;
        int n;
        point_word_t w;
        case (op)
            OP_CLEAR: begin
                head_idx = 0; fill = 0; cursor = ENDC;
            end
            OP_STAGE: begin
                staged[sl] = {y, x};
            end
            OP_COMMIT: begin
                if (fill < NENT) begin
                    e = fill;
                    fill++;
                    tab_count[e] = (pc > NVERT) ? 5'(NVERT) : pc;
                    tab_colour[e] = col;
                    tab_depth[e] = d;
                    for (int i = 0; i < NVERT; i++) tab_vert[e][i] = staged[i];
                    link_polygon(e, d);
                    cursor = head_idx;
                end
            end
            default: begin
                if (cursor >= ENDC || cursor >= fill) begin
                    w = '0; w.done_res = 1'b1; w.last = 1'b1;
                    expected_points.push_back(w);
                    cursor = ENDC;
                end else begin
                    e = cursor;
                    n = tab_count[e];
                    if (n == 0) n = 1;
                    for (int k = 0; k < n; k++) begin
                        w.done_res = 1'b0;
                        w.colour = tab_colour[e];
                        w.count = tab_count[e];
                        w.slot = 4'(k);
                        w.x = tab_vert[e][k][15:0];
                        w.y = tab_vert[e][k][31:16];
                        w.last = (k + 1 == n);
                        expected_points.push_back(w);
                    end
                    cursor = tab_link[e];
                end
            end
        endcase
    endtask

    task automatic send_word(input logic [1:0] op, input logic [3:0] sl,
                             input logic [15:0] x, input logic [15:0] y,
                             input logic [4:0] pc, input logic [7:0] col,
                             input logic [31:0] d);
        int gap;
        gap = 0;
        if (send_idle > 0 && $urandom_range(99) < send_idle) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op; s_vertex_slot <= sl; s_vertex_x <= x; s_vertex_y <= y;
        s_point_count <= pc; s_colour <= col; s_depth <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict(op, sl, x, y, pc, col, d);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic stage_all();
        for (int i = 0; i < NVERT; i++)
            send_word(OP_STAGE, 4'(i), 16'($urandom), 16'($urandom), 0, 0, 0);
    endtask

    task automatic test_directed();
        send_word(OP_EMIT, 0, 0, 0, 0, 0, 0);
        send_word(OP_STAGE, 0, 16'h8000, 16'h7fff, 0, 0, 0);
        send_word(OP_STAGE, 15, 16'h7fff, 16'h8000, 0, 0, 0);
        send_word(OP_STAGE, 1, 16'hffff, 16'h0000, 0, 0, 0);
        send_word(OP_COMMIT, 0, 0, 0, 5'd0, 8'h00, 32'h8000_0000);
        send_word(OP_COMMIT, 0, 0, 0, 5'd31, 8'hff, 32'h7fff_ffff);
        send_word(OP_COMMIT, 0, 0, 0, 5'd16, 8'h5a, 32'd0);
        send_word(OP_COMMIT, 0, 0, 0, 5'd2, 8'ha5, 32'd0);
        send_word(OP_COMMIT, 0, 0, 0, 5'd17, 8'h11, 32'hffff_ffff);
        send_word(OP_EMIT, 0, 0, 0, 0, 0, 0);
        send_word(OP_EMIT, 0, 0, 0, 0, 0, 0);
        send_word(OP_COMMIT, 0, 0, 0, 5'd1, 8'h22, 32'd0);
        for (int i = 0; i < 8; i++) send_word(OP_EMIT, 0, 0, 0, 0, 0, 0);
        send_word(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        send_word(OP_EMIT, 0, 0, 0, 0, 0, 0);
        drain();
    endtask

    task automatic test_full_table();
        send_word(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < NENT + 3; i++)
            send_word(OP_COMMIT, 0, 0, 0, 5'($urandom_range(0, 3)), 8'($urandom),
                      32'($signed($urandom_range(0, 8)) - 4));
        for (int i = 0; i < 6; i++) send_word(OP_EMIT, 0, 0, 0, 0, 0, 0);
        drain();
    endtask

    task automatic test_random(input int items);
        int r;
        logic [31:0] d;
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(99);
            if ($urandom_range(1)) d = 32'($signed($urandom_range(0, 6)) - 3);
            else d = $urandom;
            if (r < 3) send_word(OP_CLEAR, 4'($urandom), 16'($urandom), 16'($urandom),
                                 5'($urandom), 8'($urandom), $urandom);
            else if (r < 45) send_word(OP_STAGE, 4'($urandom), 16'($urandom),
                                       16'($urandom), 5'($urandom), 8'($urandom), $urandom);
            else if (r < 65) send_word(OP_COMMIT, 4'($urandom), 16'($urandom),
                                       16'($urandom),
                                       ($urandom_range(9) == 0) ? 5'($urandom) :
                                       5'($urandom_range(0, 5)), 8'($urandom), d);
            else send_word(OP_EMIT, 4'($urandom), 16'($urandom), 16'($urandom),
                           5'($urandom), 8'($urandom), $urandom);
        end
        drain();
    endtask

    task automatic test_backpressure();
        send_word(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        stage_all();
        send_word(OP_COMMIT, 0, 0, 0, 5'd16, 8'h33, 32'd5);
        hold_off = 1;
        fork
            begin
                repeat (400) @(posedge aclk);
                hold_off = 0;
            end
            for (int i = 0; i < 6; i++) send_word(OP_EMIT, 0, 0, 0, 0, 0, 0);
        join
        drain();
    endtask

    initial begin
        for (int i = 0; i < NVERT; i++) staged[i] = '0;
        head_idx = 0; fill = 0; cursor = ENDC;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_table();
        send_idle = 0;  recv_stall = 0;  test_random(70);
        send_idle = 55; recv_stall = 0;  test_random(70);
        send_idle = 0;  recv_stall = 55; test_random(70);
        send_idle = 34; recv_stall = 34; test_random(70);
        test_backpressure();
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn || hold_off) m_ready <= 1'b0;
        else m_ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
    end

    always @(posedge aclk) begin
        point_word_t w;
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_points.size() == 0) begin
                $error("output word with none expected");
                errors++;
            end else begin
                w = expected_points.pop_front();
                if (m_done_res !== w.done_res) begin
                    $error("done_res exp %0d got %0d", w.done_res, m_done_res); errors++;
                end
                if (m_out_colour !== w.colour) begin
                    $error("out_colour exp %0d got %0d", w.colour, m_out_colour); errors++;
                end
                if (m_out_count !== w.count) begin
                    $error("out_count exp %0d got %0d", w.count, m_out_count); errors++;
                end
                if (m_out_slot !== w.slot) begin
                    $error("out_slot exp %0d got %0d", w.slot, m_out_slot); errors++;
                end
                if (m_out_x !== w.x) begin
                    $error("out_x exp %0d got %0d", $signed(w.x), m_out_x); errors++;
                end
                if (m_out_y !== w.y) begin
                    $error("out_y exp %0d got %0d", $signed(w.y), m_out_y); errors++;
                end
                if (m_last_point !== w.last) begin
                    $error("last_point exp %0d got %0d", w.last, m_last_point); errors++;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* sim.f */
hdl/dspl_pkg.sv
hdl/dspl_ram.sv
hdl/depth_sorted_polygon_list.sv
tb/tb.sv
